>>> rtl/core/ptt_pkg.sv
`timescale 1ns / 1ps
package ptt_pkg;

  // result format
  localparam int WEIGHT_BITS = 20;
  localparam int TOL_BITS    = 16;
  // quotient bits kept by the divider: two above the weight width
  localparam int QUOT_BITS   = WEIGHT_BITS + 2;

  localparam int NUM_VTX = 4;
  localparam int NUM_DET = NUM_VTX + 1;

  // decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // register map
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_VTX_A = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_VTX_B = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_VTX_C = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_VTX_D = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOL   = 3'd4;

  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

  typedef logic signed [WEIGHT_BITS-1:0] ptt_weight_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ptt_q_status_t;

endpackage

>>> rtl/core/ptt_front.sv
`timescale 1ns / 1ps
module ptt_front import ptt_pkg::*; #(
  parameter int COORD_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [COORD_BITS-1:0]         point_x,
  input  logic signed [COORD_BITS-1:0]         point_y,
  input  logic signed [COORD_BITS-1:0]         point_z,
  input  logic [3*COORD_BITS-1:0]              vtx [NUM_VTX],
  output logic                                 dets_valid,
  output logic [NUM_DET*(3*COORD_BITS+4)-1:0]  dets
);

  localparam int DW    = COORD_BITS + 1;      // edge vector component
  localparam int MW    = 2 * DW;              // cross product term
  localparam int CW    = MW + 1;              // cross product component
  localparam int LO    = (CW + 1) / 2;        // low slice of split multiply
  localparam int PLW   = DW + LO + 1;
  localparam int PHW   = DW + CW - LO;
  localparam int DET_W = 3 * COORD_BITS + 4;
  localparam int NST   = 6;

  logic [NST-1:0] v_r;

  logic signed [COORD_BITS-1:0] pc [NUM_DET][NUM_VTX][3];
  logic signed [COORD_BITS-1:0] pq [3];

  logic signed [DW-1:0]    du_nxt [NUM_DET][3], dv_nxt [NUM_DET][3], dw_nxt [NUM_DET][3];
  logic signed [DW-1:0]    du_r   [NUM_DET][3], dv_r   [NUM_DET][3], dw_r   [NUM_DET][3];
  logic signed [MW-1:0]    m_nxt  [NUM_DET][6], m_r [NUM_DET][6];
  logic signed [DW-1:0]    u2_r   [NUM_DET][3], u3_r [NUM_DET][3];
  logic signed [CW-1:0]    c_nxt  [NUM_DET][3], c_r [NUM_DET][3];
  logic signed [PLW-1:0]   pl_nxt [NUM_DET][3], pl_r [NUM_DET][3];
  logic signed [PHW-1:0]   ph_nxt [NUM_DET][3], ph_r [NUM_DET][3];
  logic signed [DET_W-1:0] p_nxt  [NUM_DET][3], p_r [NUM_DET][3];
  logic signed [DET_W-1:0] det_nxt [NUM_DET], det_r [NUM_DET];

  assign pq[0] = point_x;
  assign pq[1] = point_y;
  assign pq[2] = point_z;

  // det 0 uses the stored vertices; det k+1 has vertex k swapped for the point
  always_comb begin
    for (int d = 0; d < NUM_DET; d++) begin
      for (int p = 0; p < NUM_VTX; p++) begin
        for (int i = 0; i < 3; i++) begin
          if (d == p + 1) begin
            pc[d][p][i] = pq[i];
          end else begin
            pc[d][p][i] = $signed(vtx[p][i*COORD_BITS +: COORD_BITS]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < NUM_DET; d++) begin
      for (int i = 0; i < 3; i++) begin
        du_nxt[d][i] = DW'(pc[d][1][i]) - DW'(pc[d][0][i]);
        dv_nxt[d][i] = DW'(pc[d][2][i]) - DW'(pc[d][0][i]);
        dw_nxt[d][i] = DW'(pc[d][3][i]) - DW'(pc[d][0][i]);
      end
      m_nxt[d][0] = dv_r[d][1] * dw_r[d][2];
      m_nxt[d][1] = dv_r[d][2] * dw_r[d][1];
      m_nxt[d][2] = dv_r[d][2] * dw_r[d][0];
      m_nxt[d][3] = dv_r[d][0] * dw_r[d][2];
      m_nxt[d][4] = dv_r[d][0] * dw_r[d][1];
      m_nxt[d][5] = dv_r[d][1] * dw_r[d][0];
      for (int i = 0; i < 3; i++) begin
        c_nxt[d][i]  = CW'(m_r[d][2*i]) - CW'(m_r[d][2*i+1]);
        // split the wide operand so each multiply stays narrow
        pl_nxt[d][i] = u3_r[d][i] * $signed({1'b0, c_r[d][i][LO-1:0]});
        ph_nxt[d][i] = u3_r[d][i] * $signed(c_r[d][i][CW-1:LO]);
        p_nxt[d][i]  = (DET_W'(ph_r[d][i]) <<< LO) + DET_W'(pl_r[d][i]);
      end
      det_nxt[d] = p_r[d][0] + p_r[d][1] + p_r[d][2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      du_r  <= du_nxt;
      dv_r  <= dv_nxt;
      dw_r  <= dw_nxt;
      m_r   <= m_nxt;
      u2_r  <= du_r;
      c_r   <= c_nxt;
      u3_r  <= u2_r;
      pl_r  <= pl_nxt;
      ph_r  <= ph_nxt;
      p_r   <= p_nxt;
      det_r <= det_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  always_comb begin
    for (int d = 0; d < NUM_DET; d++) begin
      dets[d*DET_W +: DET_W] = det_r[d];
    end
  end

  assign dets_valid = v_r[NST-1];

endmodule

>>> rtl/core/ptt_queue.sv
`timescale 1ns / 1ps
module ptt_queue import ptt_pkg::*; #(
  parameter int W = 320
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  push_data,
  input  logic          pop,
  output logic [W-1:0]  pop_data,
  output ptt_q_status_t status
);

  logic [W-1:0]      mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign pop_data     = mem[rd_r];
  assign status.full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);

endmodule

>>> rtl/core/ptt_back.sv
`timescale 1ns / 1ps
module ptt_back import ptt_pkg::*; #(
  parameter int COORD_BITS       = 20,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [NUM_DET*(3*COORD_BITS+4)-1:0] dets,
  input  logic [TOL_BITS-1:0]                 tol,
  output logic                                out_valid,
  output ptt_weight_t                         out_w [NUM_VTX],
  output logic                                out_inside,
  output logic                                out_degen
);

  localparam int DET_W = 3 * COORD_BITS + 4;
  localparam int MW    = DET_W - 1;
  localparam int QB    = QUOT_BITS;
  localparam int RW    = MW + WEIGHT_FRAC_BITS + QB + 1;
  localparam int FW    = QB + 2;

  // stage B0: sign normalise
  logic signed [DET_W-1:0] det0, nn [NUM_VTX];
  logic [MW-1:0]           mag_nxt [NUM_VTX], den_nxt;
  logic                    sn_nxt [NUM_VTX];
  logic [MW-1:0]           mag_r [NUM_VTX], den0_r;
  logic                    sn0_r [NUM_VTX];
  logic                    deg0_r, v0_r;

  // divider pipe, index 0 is the set-up stage
  logic [RW-1:0] rem_r [QB+1][NUM_VTX];
  logic [QB-1:0] q_r   [QB+1][NUM_VTX];
  logic          sn_r  [QB+1][NUM_VTX];
  logic          ovf_r [QB+1][NUM_VTX];
  logic [MW-1:0] den_r [QB+1];
  logic          deg_r [QB+1];
  logic          v_r   [QB+1];

  // fix-up stage
  logic signed [QB:0] q2_nxt [NUM_VTX], q2_r [NUM_VTX];
  logic               degf_r, vf_r;

  // output stage
  logic signed [FW-1:0] q2e, rnd, flr, neg_tol;
  logic signed [FW-1:0] wmax, wmin;
  ptt_weight_t          w_nxt [NUM_VTX], w_r [NUM_VTX];
  logic                 ins_nxt, ins_r, degout_r, vout_r;

  always_comb begin
    det0    = $signed(dets[0 +: DET_W]);
    den_nxt = det0[DET_W-1] ? MW'(-det0) : MW'(det0);
    for (int k = 0; k < NUM_VTX; k++) begin
      nn[k]      = det0[DET_W-1] ? -$signed(dets[(k+1)*DET_W +: DET_W])
                                 :  $signed(dets[(k+1)*DET_W +: DET_W]);
      sn_nxt[k]  = nn[k][DET_W-1];
      mag_nxt[k] = sn_nxt[k] ? MW'(-nn[k]) : MW'(nn[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag_nxt;
      sn0_r  <= sn_nxt;
      den0_r <= den_nxt;
      deg0_r <= (det0 == '0);
    end
  end

  // set-up: scaled numerator and range check against 2^QB quotient
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_VTX; k++) begin
        rem_r[0][k] <= RW'(mag_r[k]) << (WEIGHT_FRAC_BITS + 1);
        ovf_r[0][k] <= (RW'(mag_r[k]) << (WEIGHT_FRAC_BITS + 1)) >= (RW'(den0_r) << QB);
        sn_r[0][k]  <= sn0_r[k];
        q_r[0][k]   <= '0;
      end
      den_r[0] <= den0_r;
      deg_r[0] <= deg0_r;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar s = 1; s <= QB; s++) begin : g_div
    logic [RW-1:0] dsh;
    logic          ge [NUM_VTX];
    always_comb begin
      dsh = RW'(den_r[s-1]) << (QB - s);
      for (int k = 0; k < NUM_VTX; k++) begin
        ge[k] = rem_r[s-1][k] >= dsh;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < NUM_VTX; k++) begin
          rem_r[s][k] <= ge[k] ? rem_r[s-1][k] - dsh : rem_r[s-1][k];
          q_r[s][k]   <= {q_r[s-1][k][QB-2:0], ge[k]};
          sn_r[s][k]  <= sn_r[s-1][k];
          ovf_r[s][k] <= ovf_r[s-1][k];
        end
        den_r[s] <= den_r[s-1];
        deg_r[s] <= deg_r[s-1];
      end
    end
  end

  // floor quotient of the signed ratio, clamped to QB+1 bits
  always_comb begin
    for (int k = 0; k < NUM_VTX; k++) begin
      if (!sn_r[QB][k]) begin
        q2_nxt[k] = ovf_r[QB][k] ? $signed({1'b0, {QB{1'b1}}}) : $signed({1'b0, q_r[QB][k]});
      end else if (ovf_r[QB][k]) begin
        q2_nxt[k] = $signed({1'b1, {QB{1'b0}}});
      end else begin
        q2_nxt[k] = -$signed({1'b0, q_r[QB][k]})
                    - $signed((QB+1)'(rem_r[QB][k] != '0));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q2_r   <= q2_nxt;
      degf_r <= deg_r[QB];
    end
  end

  // round half up, saturate, tolerance check on the floor quotient
  always_comb begin
    wmax    = FW'($signed({1'b0, {(WEIGHT_BITS-1){1'b1}}}));
    wmin    = FW'($signed({1'b1, {(WEIGHT_BITS-1){1'b0}}}));
    neg_tol = -$signed(FW'(tol));
    ins_nxt = !degf_r;
    q2e     = '0;
    rnd     = '0;
    flr     = '0;
    for (int k = 0; k < NUM_VTX; k++) begin
      q2e = FW'(q2_r[k]);
      rnd = (q2e + FW'(1)) >>> 1;
      flr = q2e >>> 1;
      if (flr < neg_tol) begin
        ins_nxt = 1'b0;
      end
      if (degf_r) begin
        w_nxt[k] = '0;
      end else if (rnd > wmax) begin
        w_nxt[k] = wmax[WEIGHT_BITS-1:0];
      end else if (rnd < wmin) begin
        w_nxt[k] = wmin[WEIGHT_BITS-1:0];
      end else begin
        w_nxt[k] = rnd[WEIGHT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r      <= w_nxt;
      ins_r    <= ins_nxt;
      degout_r <= degf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      vf_r   <= 1'b0;
      vout_r <= 1'b0;
      for (int s = 0; s <= QB; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (en) begin
      v0_r <= in_valid;
      v_r[0] <= v0_r;
      for (int s = 1; s <= QB; s++) begin
        v_r[s] <= v_r[s-1];
      end
      vf_r   <= v_r[QB];
      vout_r <= vf_r;
    end
  end

  assign out_valid  = vout_r;
  assign out_w      = w_r;
  assign out_inside = ins_r;
  assign out_degen  = degout_r;

endmodule

>>> rtl/core/point_in_tetrahedron_test_core.sv
`timescale 1ns / 1ps
// Throughput: one point per cycle while in_stall is low; six determinant stages, 22 divider stages.
// A four-entry queue decouples the determinant front end from the divider back end.
// Reset (rst_n low, synchronous) empties all pipes; vertices clear to 0, tolerance to 1.
// With all-zero vertices every result is flagged degenerate until the vertices are written.
module point_in_tetrahedron_test_core import ptt_pkg::*; #(
  parameter int COORD_BITS       = 20,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // query beats
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  // result beats
  output logic                         out_valid,
  input  logic                         out_stall,
  output ptt_weight_t                  out_weight_a,
  output ptt_weight_t                  out_weight_b,
  output ptt_weight_t                  out_weight_c,
  output ptt_weight_t                  out_weight_d,
  output logic                         out_inside_res,
  output logic                         out_degenerate,
  // register writes
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [3*COORD_BITS-1:0]      cfg_wdata
);

  localparam int DET_W = 3 * COORD_BITS + 4;
  localparam int QW    = NUM_DET * DET_W;

  // vertex and tolerance registers; the user must write them only while the block is idle
  // (the block itself does not enforce this), so the pipes read them directly
  logic [3*COORD_BITS-1:0] vtx_r [NUM_VTX];
  logic [TOL_BITS-1:0]     tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_VTX; k++) begin
        vtx_r[k] <= '0;
      end
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VTX_A: vtx_r[0] <= cfg_wdata;
        REG_VTX_B: vtx_r[1] <= cfg_wdata;
        REG_VTX_C: vtx_r[2] <= cfg_wdata;
        REG_VTX_D: vtx_r[3] <= cfg_wdata;
        REG_TOL:   tol_r    <= cfg_wdata[TOL_BITS-1:0];
        default:   ;  // unmapped index: write dropped
      endcase
    end
  end

  // front end: five 3x3 determinants per point, held whole while the queue is full
  ptt_q_status_t q_status;
  logic          front_en, dets_valid;
  logic [QW-1:0] dets_front, dets_back;

  assign front_en = !q_status.full;
  assign in_stall = q_status.full;

  ptt_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (front_en),
    .in_valid   (in_valid),
    .point_x    (in_point_x),
    .point_y    (in_point_y),
    .point_z    (in_point_z),
    .vtx        (vtx_r),
    .dets_valid (dets_valid),
    .dets       (dets_front)
  );

  // back end moves whenever its output register is free or being taken
  logic        back_en, pop;
  ptt_weight_t w [NUM_VTX];

  assign back_en = !out_valid || !out_stall;
  assign pop     = back_en && !q_status.empty;

  ptt_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_en && dets_valid),
    .push_data (dets_front),
    .pop       (pop),
    .pop_data  (dets_back),
    .status    (q_status)
  );

  ptt_back #(
    .COORD_BITS       (COORD_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (back_en),
    .in_valid   (pop),
    .dets       (dets_back),
    .tol        (tol_r),
    .out_valid  (out_valid),
    .out_w      (w),
    .out_inside (out_inside_res),
    .out_degen  (out_degenerate)
  );

  assign out_weight_a = w[0];
  assign out_weight_b = w[1];
  assign out_weight_c = w[2];
  assign out_weight_d = w[3];

endmodule

>>> rtl/core/ptt_checker.sv
`timescale 1ns / 1ps
module ptt_checker import ptt_pkg::*; #(
  parameter int COORD_BITS = 20
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic signed [COORD_BITS-1:0] in_point_x,
  input logic signed [COORD_BITS-1:0] in_point_y,
  input logic signed [COORD_BITS-1:0] in_point_z,
  input logic                         out_valid,
  input logic                         out_stall,
  input ptt_weight_t                  out_weight_a,
  input ptt_weight_t                  out_weight_b,
  input ptt_weight_t                  out_weight_c,
  input ptt_weight_t                  out_weight_d,
  input logic                         out_inside_res,
  input logic                         out_degenerate,
  input logic                         cfg_we,
  input logic [CFG_IDX_BITS-1:0]      cfg_index,
  input logic [3*COORD_BITS-1:0]      cfg_wdata
);

  logic [TOL_BITS-1:0]          tol_r;
  logic signed [WEIGHT_BITS:0]  neg_tol;
  logic                         any_low;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we && cfg_index == REG_TOL) begin
      tol_r <= cfg_wdata[TOL_BITS-1:0];
    end
  end

  assign neg_tol = -$signed((WEIGHT_BITS+1)'(tol_r));
  assign any_low = ((WEIGHT_BITS+1)'(out_weight_a) < neg_tol)
                || ((WEIGHT_BITS+1)'(out_weight_b) < neg_tol)
                || ((WEIGHT_BITS+1)'(out_weight_c) < neg_tol)
                || ((WEIGHT_BITS+1)'(out_weight_d) < neg_tol);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_point_x) && $stable(in_point_y)
                             && $stable(in_point_z))
    else $error("stalled query beat changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_weight_a) && $stable(out_weight_d)
                               && $stable(out_inside_res) && $stable(out_degenerate))
    else $error("stalled result beat changed");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_weight_a == '0 && out_weight_b == '0
                                    && out_weight_c == '0 && out_weight_d == '0
                                    && !out_inside_res)
    else $error("degenerate result carries weights or inside flag");

  a_low_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate && any_low |-> !out_inside_res)
    else $error("weight below tolerance reported inside");

endmodule

bind point_in_tetrahedron_test_core ptt_checker #(.COORD_BITS(COORD_BITS)) u_ptt_checker (.*);

>>> dv/tb_point_in_tetrahedron_test_core.sv
`timescale 1ns / 1ps
module tb_point_in_tetrahedron_test_core;
  import ptt_pkg::*;

  localparam int CB          = 20;
  localparam int FRAC        = 16;
  localparam int DRAIN_WAIT  = 40;      // margin beyond the pipe depth
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int RAND_ITEMS  = 50;      // beats per random phase
  // index outside the register map; a write there must change nothing
  localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;

  localparam logic signed [CB-1:0] C_MAX = 20'sh7FFFF;
  localparam logic signed [CB-1:0] C_MIN = -20'sh80000;
  localparam logic signed [CB-1:0] ONE   = 20'sd4096;     // 1.0 in Q8.12
  localparam ptt_weight_t W_ONE = 20'sd65536;             // 1.0 in weight units
  localparam ptt_weight_t W_MAX = 20'sh7FFFF;
  localparam ptt_weight_t W_MIN = -20'sh80000;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    ptt_weight_t wa, wb, wc, wd;
    logic        in_tet;
    logic        degen;
  } bary_t;

  // directed rows: vertex set, point, and where obvious the result itself
  typedef enum int {
    SET_RESET,    // after reset: all vertices zero
    SET_UNIT,     // unit corner tetrahedron, zero tolerance
    SET_MIRROR,   // B and C swapped: negative base determinant
    SET_FLAT      // D in the plane of A, B, C
  } vset_e;

  typedef struct {
    vset_e               vset;
    logic signed [CB-1:0] px, py, pz;
    bit                  typed;
    bary_t               res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ptt_weight_t out_weight_a, out_weight_b, out_weight_c, out_weight_d;
  logic out_inside_res, out_degenerate;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_VTX_A;
  logic [3*CB-1:0] cfg_wdata = '0;

  // shadow of the block's registers
  logic [3*CB-1:0] vtx_shadow [NUM_VTX];
  logic [TOL_BITS-1:0] tol_shadow;

  bary_t weights_due [$];
  int    err_count = 0;
  int    cycle_count = 0;
  int    idle_mode = 0;   // 0: sender 35 / receiver 46, 1: swapped, 2: none
  row_t  rows [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  point_in_tetrahedron_test_core DUT (.*);

  function automatic void due_add(bary_t b);
    weights_due.insert(weights_due.size(), b);
  endfunction

  function automatic void row_add(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  function automatic wide_t sx(logic [CB-1:0] b);
    logic signed [CB-1:0] s;
    wide_t r;
    s = b;
    r = s;
    return r;
  endfunction

  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if (n % d != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // det[P1-P0; P2-P0; P3-P0]
  function automatic wide_t det4(wide_t p0x, wide_t p0y, wide_t p0z,
                                 wide_t p1x, wide_t p1y, wide_t p1z,
                                 wide_t p2x, wide_t p2y, wide_t p2z,
                                 wide_t p3x, wide_t p3y, wide_t p3z);
    wide_t ux, uy, uz, vx, vy, vz, wx, wy, wz;
    ux = p1x - p0x; uy = p1y - p0y; uz = p1z - p0z;
    vx = p2x - p0x; vy = p2y - p0y; vz = p2z - p0z;
    wx = p3x - p0x; wy = p3y - p0y; wz = p3z - p0z;
    return ux * (vy * wz - vz * wy) + uy * (vz * wx - vx * wz) + uz * (vx * wy - vy * wx);
  endfunction

  function automatic bary_t predict_bary(logic [CB-1:0] px, logic [CB-1:0] py,
                                         logic [CB-1:0] pz);
    wide_t vx [NUM_VTX], vy [NUM_VTX], vz [NUM_VTX];
    wide_t tx [NUM_VTX], ty [NUM_VTX], tz [NUM_VTX];
    wide_t base, den, num, q, r;
    ptt_weight_t w [NUM_VTX];
    bary_t res;
    bit neg;
    res = '0;
    for (int k = 0; k < NUM_VTX; k++) begin
      vx[k] = sx(vtx_shadow[k][CB-1:0]);
      vy[k] = sx(vtx_shadow[k][2*CB-1:CB]);
      vz[k] = sx(vtx_shadow[k][3*CB-1:2*CB]);
    end
    base = det4(vx[0], vy[0], vz[0], vx[1], vy[1], vz[1],
                vx[2], vy[2], vz[2], vx[3], vy[3], vz[3]);
    if (base == 0) begin
      res.degen = 1'b1;
      return res;
    end
    neg = base < 0;
    den = neg ? -base : base;
    res.in_tet = 1'b1;
    for (int k = 0; k < NUM_VTX; k++) begin
      for (int j = 0; j < NUM_VTX; j++) begin
        tx[j] = (j == k) ? sx(px) : vx[j];
        ty[j] = (j == k) ? sx(py) : vy[j];
        tz[j] = (j == k) ? sx(pz) : vz[j];
      end
      num = det4(tx[0], ty[0], tz[0], tx[1], ty[1], tz[1],
                 tx[2], ty[2], tz[2], tx[3], ty[3], tz[3]);
      if (neg) num = -num;
      // inside test on the exact ratio, not the rounded weight
      q = floor_div(num <<< FRAC, den);
      if (q < -wide_t'(tol_shadow)) res.in_tet = 1'b0;
      r = floor_div((num <<< (FRAC + 1)) + den, den <<< 1);   // round half up
      if (r > wide_t'(W_MAX)) r = W_MAX;
      if (r < wide_t'(W_MIN)) r = W_MIN;
      w[k] = r[WEIGHT_BITS-1:0];
    end
    res.wa = w[0]; res.wb = w[1]; res.wc = w[2]; res.wd = w[3];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH t=%0t %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // result side: random stall per idle mode, check every accepted beat
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case (idle_mode)
      0: out_stall <= ($urandom_range(99) < 46);
      1: out_stall <= ($urandom_range(99) < 35);
      default: out_stall <= 1'b0;
    endcase
    if (rst_n && out_valid && !out_stall) begin
      if (weights_due.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", 1, 0);
      end else begin
        bary_t want;
        want = weights_due.pop_front();
        if (out_weight_a !== want.wa) report_mismatch("weight_a", out_weight_a, want.wa);
        if (out_weight_b !== want.wb) report_mismatch("weight_b", out_weight_b, want.wb);
        if (out_weight_c !== want.wc) report_mismatch("weight_c", out_weight_c, want.wc);
        if (out_weight_d !== want.wd) report_mismatch("weight_d", out_weight_d, want.wd);
        if (out_inside_res !== want.in_tet)
          report_mismatch("inside_res", out_inside_res, want.in_tet);
        if (out_degenerate !== want.degen)
          report_mismatch("degenerate", out_degenerate, want.degen);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // wait for the pipe to empty before touching registers
  task automatic drain_pipe();
    while (weights_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [3*CB-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx < NUM_VTX) vtx_shadow[idx] = data;
    else if (idx == REG_TOL) tol_shadow = data[TOL_BITS-1:0];
  endtask

  function automatic logic [3*CB-1:0] pack_xyz(logic [CB-1:0] x, logic [CB-1:0] y,
                                               logic [CB-1:0] z);
    return {z, y, x};
  endfunction

  task automatic load_tetra(logic [3*CB-1:0] a, logic [3*CB-1:0] b, logic [3*CB-1:0] c,
                            logic [3*CB-1:0] d, logic [TOL_BITS-1:0] tol);
    drain_pipe();
    write_reg(REG_VTX_A, a);
    write_reg(REG_VTX_B, b);
    write_reg(REG_VTX_C, c);
    write_reg(REG_VTX_D, d);
    write_reg(REG_TOL, {{(3*CB-TOL_BITS){1'b0}}, tol});
    cfg_we <= 1'b0;
  endtask

  task automatic apply_vset(vset_e s);
    case (s)
      SET_UNIT:   load_tetra('0, pack_xyz(ONE, 0, 0), pack_xyz(0, ONE, 0),
                             pack_xyz(0, 0, ONE), '0);
      SET_MIRROR: load_tetra('0, pack_xyz(0, ONE, 0), pack_xyz(ONE, 0, 0),
                             pack_xyz(0, 0, ONE), 16'd1);
      SET_FLAT:   load_tetra('0, pack_xyz(ONE, 0, 0), pack_xyz(0, ONE, 0),
                             pack_xyz(ONE, ONE, 0), 16'hFFFF);
      default: ;
    endcase
  endtask

  // one beat: optional gap, then hold until accepted; expectation queued on accept
  task automatic send_point(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z,
                            bit typed, bary_t want);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 35 : (idle_mode == 1) ? 46 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (!(in_valid && !in_stall));
    due_add(typed ? want : predict_bary(x, y, z));
  endtask

  function automatic row_t mk(vset_e s, logic [CB-1:0] x, logic [CB-1:0] y,
                              logic [CB-1:0] z, bit typed, bary_t res);
    row_t r;
    r.vset = s; r.px = x; r.py = y; r.pz = z; r.typed = typed; r.res = res;
    return r;
  endfunction

  function automatic logic [CB-1:0] rand_coord(int span);
    if (span == 0) return CB'($urandom());
    return CB'($urandom_range(2 * span) - span);
  endfunction

  initial begin
    bary_t none, degen_res;
    vset_e cur;
    int span;
    logic [CB-1:0] vx [NUM_VTX], vy [NUM_VTX], vz [NUM_VTX];
    logic [TOL_BITS-1:0] tol;

    none = '0;
    degen_res = '0;
    degen_res.degen = 1'b1;
    for (int k = 0; k < NUM_VTX; k++) vtx_shadow[k] = '0;
    tol_shadow = TOL_RESET;

    // after reset every query is degenerate
    row_add(mk(SET_RESET, 0, 0, 0, 1, degen_res));
    row_add(mk(SET_RESET, C_MAX, C_MIN, C_MAX, 1, degen_res));
    // unit tetrahedron: corners give unit weights, far corners saturate
    row_add(mk(SET_UNIT, 0, 0, 0, 1, '{W_ONE, 0, 0, 0, 1'b1, 1'b0}));
    row_add(mk(SET_UNIT, ONE, 0, 0, 1, '{0, W_ONE, 0, 0, 1'b1, 1'b0}));
    row_add(mk(SET_UNIT, 0, 0, ONE, 1, '{0, 0, 0, W_ONE, 1'b1, 1'b0}));
    row_add(mk(SET_UNIT, C_MAX, C_MAX, C_MAX, 1, '{W_MIN, W_MAX, W_MAX, W_MAX, 1'b0, 1'b0}));
    row_add(mk(SET_UNIT, C_MIN, C_MIN, C_MIN, 1, '{W_MAX, W_MIN, W_MIN, W_MIN, 1'b0, 1'b0}));
    row_add(mk(SET_UNIT, 1024, 1024, 1024, 0, none));      // centroid
    row_add(mk(SET_UNIT, 2048, 2048, 0, 0, none));         // on a face
    row_add(mk(SET_UNIT, -1, 0, 0, 0, none));              // just outside, zero tolerance
    row_add(mk(SET_UNIT, 1, 1, 1, 0, none));               // rounding near a corner
    row_add(mk(SET_UNIT, 1365, 1365, 1366, 0, none));
    // negative base determinant
    row_add(mk(SET_MIRROR, 1024, 1024, 1024, 0, none));
    row_add(mk(SET_MIRROR, -3, 500, 700, 0, none));
    row_add(mk(SET_MIRROR, C_MAX, C_MIN, 0, 0, none));
    // coplanar vertices: degenerate even with nonzero registers
    row_add(mk(SET_FLAT, 100, 200, 300, 1, degen_res));
    row_add(mk(SET_FLAT, C_MIN, C_MAX, C_MIN, 1, degen_res));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur = SET_RESET;
    foreach (rows[i]) begin
      if (rows[i].vset != cur) begin
        in_valid <= 1'b0;
        apply_vset(rows[i].vset);
        cur = rows[i].vset;
      end
      send_point(rows[i].px, rows[i].py, rows[i].pz, rows[i].typed, rows[i].res);
    end

    // unmapped index: tetrahedron must stay flat, so still degenerate
    in_valid <= 1'b0;
    drain_pipe();
    write_reg(REG_UNMAPPED, '1);
    cfg_we <= 1'b0;
    send_point(5, 6, 7, 1, degen_res);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      in_valid <= 1'b0;
      idle_mode = (ph * 3) / RAND_PHASES;
      if (ph == 2) begin
        // extreme corners, largest tolerance
        load_tetra(pack_xyz(C_MIN, C_MIN, C_MIN), pack_xyz(C_MAX, C_MIN, C_MIN),
                   pack_xyz(C_MIN, C_MAX, C_MIN), pack_xyz(C_MIN, C_MIN, C_MAX), 16'hFFFF);
        span = 0;
      end else begin
        // mostly small tetrahedra so that points fall inside often
        span = (ph == 5) ? 0 : (ph % 2) ? 8192 : 1024;
        for (int k = 0; k < NUM_VTX; k++) begin
          vx[k] = rand_coord(span);
          vy[k] = rand_coord(span);
          vz[k] = rand_coord(span);
        end
        tol = (ph == 0) ? 16'd0 : (ph == 7) ? 16'hFFFF : 16'($urandom_range(4096));
        load_tetra(pack_xyz(vx[0], vy[0], vz[0]), pack_xyz(vx[1], vy[1], vz[1]),
                   pack_xyz(vx[2], vy[2], vz[2]), pack_xyz(vx[3], vy[3], vz[3]), tol);
      end
      for (int n = 0; n < RAND_ITEMS; n++) begin
        if ($urandom_range(9) < 6 && span != 0)
          send_point(rand_coord(span), rand_coord(span), rand_coord(span), 0, none);
        else
          send_point(CB'($urandom()), CB'($urandom()), CB'($urandom()), 0, none);
      end
    end
    in_valid <= 1'b0;

    drain_pipe();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ptt_pkg.sv
rtl/core/ptt_front.sv
rtl/core/ptt_queue.sv
rtl/core/ptt_back.sv
rtl/core/point_in_tetrahedron_test_core.sv
rtl/core/ptt_checker.sv
dv/tb_point_in_tetrahedron_test_core.sv
